### hdl/stlcg_pkg.sv
// Shared types and fixed constants of the shuffled three-generator uniform source.
package stlcg_pkg;

    // Request and response payloads.
    typedef struct packed {
        logic        opcode;
        logic [30:0] seed_magnitude;
    } t_req;

    typedef struct packed {
        logic [31:0] deviate_q32;
        logic [35:0] combined_raw;
    } t_rsp;

    localparam logic OP_RESEED = 1'b1;

    // Generator indexes and update masks.
    localparam int GEN_A = 0;
    localparam int GEN_B = 1;
    localparam int GEN_C = 2;

    localparam logic [2:0] MASK_A   = 3'b001;
    localparam logic [2:0] MASK_AB  = 3'b011;
    localparam logic [2:0] MASK_ALL = 3'b111;

    // Generator constants.
    localparam logic [17:0] MOD_A = 18'd259200;
    localparam logic [17:0] MOD_B = 18'd134456;
    localparam logic [17:0] MOD_C = 18'd243000;

    localparam logic [17:0] GEN_MOD [0:2] = '{MOD_A, MOD_B, MOD_C};
    localparam logic [12:0] GEN_MUL [0:2] = '{13'd7141, 13'd8121, 13'd4561};
    localparam logic [15:0] GEN_INC [0:2] = '{16'd54773, 16'd28411, 16'd51349};

    // floor(2^32 / modulus); the estimated quotient is exact or one low.
    localparam logic [14:0] GEN_RECIP [0:2] = '{15'd16570, 15'd31943, 15'd17674};

    // MOD_A * MOD_B, the span of a table value.
    localparam logic [35:0] RAW_SPAN = 36'd34850995200;

endpackage

### hdl/stlcg_if.sv
// Request and response channel interfaces with valid/ready handshake.
interface stlcg_req_if;
    logic             valid;
    logic             ready;
    stlcg_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface stlcg_rsp_if;
    logic             valid;
    logic             ready;
    stlcg_pkg::t_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/shuffled_triple_lcg_uniform_rng.sv
// Top level of the shuffled three-generator uniform random source.
//
//  channel  direction  payload                          request taken when
//  i_req    in         opcode, seed_magnitude           valid && ready
//  o_rsp    out        deviate_q32, combined_raw        valid && ready
//
// A draw runs through generator arithmetic (MUL, QUO, REM, FIX), table value and slot
// (PACK, SLOT), the table read-modify-write (RW), the q0.32 conversion (CV0 to CV3) and
// the output load (OUT), then returns to idle. A reseed (or the first draw after reset)
// first runs the table fill. Reset is synchronous and active low and leaves the table
// uncleared. A waiting response stalls only the next result, not the next request.
module shuffled_triple_lcg_uniform_rng #(
    parameter int TABLE_DEPTH = 97
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stlcg_req_if.sink   i_req,
    stlcg_rsp_if.source o_rsp
);

    // Slot index and the exact reciprocal for floor(TABLE_DEPTH * third / MOD_C).
    // The product TABLE_DEPTH * third is below 2^X_W; with a shift of X_W plus
    // the bit length of MOD_C, the rounded-up reciprocal gives an exact quotient.
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int X_W         = SLOT_W + 18;
    localparam int SLOT_SH     = X_W + 18;
    localparam int RECIP_W     = X_W + 1;
    localparam int SLOT_PROD_W = X_W + RECIP_W;
    localparam logic [RECIP_W-1:0] SLOT_RECIP = RECIP_W'(
        ((64'd1 << SLOT_SH) + 64'(stlcg_pkg::MOD_C) - 64'd1) / 64'(stlcg_pkg::MOD_C));

    // Fraction conversion. RAW_SPAN is 2^10 times a 26-bit divisor, so the
    // fraction is floor(raw * 2^22 / CV_DIV). The raw value times the 33-bit
    // reciprocal, shifted by 36, is exact or one low; the remainder, which is
    // below 2^27 and so fits in 28 bits, decides the final increment.
    localparam int Q_W       = 32;
    localparam int CV_HALF   = 18;
    localparam int CV_PROD_W = CV_HALF + 33;
    localparam int CV_SUM_W  = CV_PROD_W + CV_HALF;
    localparam int CV_SHIFT  = 36;
    localparam logic [25:0] CV_DIV   = 26'(stlcg_pkg::RAW_SPAN >> 10);
    localparam logic [32:0] CV_RECIP = 33'((64'd1 << 58) / 64'(CV_DIV));
    localparam logic [SLOT_W-1:0]    FILL_LAST = SLOT_W'(TABLE_DEPTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_QUO,
        ST_REM,
        ST_FIX,
        ST_PACK,
        ST_FILL,
        ST_SLOT,
        ST_RW,
        ST_CV0,
        ST_CV1,
        ST_CV2,
        ST_CV3,
        ST_OUT
    } t_state;

    // What the generator step just finishing is for.
    typedef enum logic [2:0] {
        PH_SEED0,
        PH_SEED1,
        PH_SEED2,
        PH_FILL,
        PH_DRAW
    } t_phase;

    t_state                 r_state;
    t_phase                 r_phase;
    logic [2:0]             r_mask;
    logic [SLOT_W-1:0]      r_fill_idx;
    logic                   r_seeded;
    logic [17:0]            r_gen [0:2];
    logic                   r_out_valid;
    stlcg_pkg::t_rsp        r_out;

    // Generator datapath: product, quotient estimate, partial remainder.
    logic [31:0]            r_p [0:2];
    logic [15:0]            r_q [0:2];
    logic [18:0]            r_t [0:2];
    logic [47:0]            quo_prod [0:2];
    logic [17:0]            fix_val [0:2];
    logic [17:0]            first_mod_b;
    logic [17:0]            first_mod_c;

    // Table value, slot selection and the shuffle table itself.
    logic [35:0]            r_pack;
    logic [X_W-1:0]         r_slot_x;
    logic [SLOT_W-1:0]      r_slot;
    logic [SLOT_PROD_W-1:0] slot_prod;
    logic [35:0]            r_table [0:TABLE_DEPTH-1];
    logic [35:0]            r_rdata;
    logic                   mem_we;
    logic                   mem_re;
    logic [SLOT_W-1:0]      mem_addr;

    // Reciprocal conversion for floor(raw * 2^32 / RAW_SPAN).
    logic [CV_PROD_W-1:0]   r_cv_hi;
    logic [CV_PROD_W-1:0]   r_cv_lo;
    logic [Q_W-1:0]         r_qest;
    logic [27:0]            r_cv_rem;
    logic [Q_W-1:0]         r_quo;

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // Modular reduction: the quotient estimate can be one low, so the partial
    // remainder stays below twice the modulus and one subtract finishes it.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            quo_prod[i] = 48'(r_p[i]) * 48'(stlcg_pkg::GEN_RECIP[i]);
            fix_val[i]  = (r_t[i] >= 19'(stlcg_pkg::GEN_MOD[i]))
                        ? 18'(r_t[i] - 19'(stlcg_pkg::GEN_MOD[i]))
                        : r_t[i][17:0];
        end
    end

    // During seeding the other two generators start from the first one, which
    // is below twice either modulus.
    assign first_mod_b = (fix_val[stlcg_pkg::GEN_A] >= stlcg_pkg::MOD_B)
                       ? fix_val[stlcg_pkg::GEN_A] - stlcg_pkg::MOD_B
                       : fix_val[stlcg_pkg::GEN_A];
    assign first_mod_c = (fix_val[stlcg_pkg::GEN_A] >= stlcg_pkg::MOD_C)
                       ? fix_val[stlcg_pkg::GEN_A] - stlcg_pkg::MOD_C
                       : fix_val[stlcg_pkg::GEN_A];

    assign slot_prod = SLOT_PROD_W'(r_slot_x) * SLOT_PROD_W'(SLOT_RECIP);

    // Fill writes sequential entries; a draw reads the old slot value and
    // writes the fresh one in the same cycle (read-first).
    assign mem_we   = (r_state == ST_FILL) || (r_state == ST_RW);
    assign mem_re   = (r_state == ST_RW);
    assign mem_addr = (r_state == ST_FILL) ? r_fill_idx : r_slot;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_addr] <= r_pack;
        end
        if (mem_re) begin
            r_rdata <= r_table[mem_addr];
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                // Seed load; only used when the request starts a reseed.
                r_p[stlcg_pkg::GEN_A] <= 32'(stlcg_pkg::GEN_INC[stlcg_pkg::GEN_A])
                                       + 32'(i_req.data.seed_magnitude);
            end
            ST_MUL: begin
                for (int i = 0; i < 3; i++) begin
                    r_p[i] <= 32'(stlcg_pkg::GEN_MUL[i]) * 32'(r_gen[i])
                            + 32'(stlcg_pkg::GEN_INC[i]);
                end
            end
            ST_QUO: begin
                for (int i = 0; i < 3; i++) begin
                    r_q[i] <= 16'(quo_prod[i] >> 32);
                end
            end
            ST_REM: begin
                for (int i = 0; i < 3; i++) begin
                    r_t[i] <= 19'(r_p[i] - 32'(r_q[i]) * 32'(stlcg_pkg::GEN_MOD[i]));
                end
            end
            ST_PACK: begin
                r_pack   <= 36'(r_gen[stlcg_pkg::GEN_A]) * 36'(stlcg_pkg::MOD_B)
                          + 36'(r_gen[stlcg_pkg::GEN_B]);
                r_slot_x <= X_W'(TABLE_DEPTH) * X_W'(r_gen[stlcg_pkg::GEN_C]);
            end
            ST_SLOT: begin
                r_slot <= SLOT_W'(slot_prod >> SLOT_SH);
            end
            ST_CV0: begin
                // Two half-width partial products of raw times the reciprocal.
                r_cv_hi <= CV_PROD_W'(r_rdata[35:18]) * CV_PROD_W'(CV_RECIP);
                r_cv_lo <= CV_PROD_W'(r_rdata[17:0]) * CV_PROD_W'(CV_RECIP);
            end
            ST_CV1: begin
                r_qest <= Q_W'(((CV_SUM_W'(r_cv_hi) << CV_HALF) + CV_SUM_W'(r_cv_lo))
                               >> CV_SHIFT);
            end
            ST_CV2: begin
                r_cv_rem <= {r_rdata[5:0], 22'd0} - 28'(r_qest[27:0] * 28'(CV_DIV));
            end
            ST_CV3: begin
                r_quo <= r_qest + Q_W'(r_cv_rem >= 28'(CV_DIV));
            end
            default: begin
            end
        endcase
    end

    // Sequencer, generator state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_DRAW;
            r_mask      <= '0;
            r_fill_idx  <= '0;
            r_seeded    <= 1'b0;
            r_gen       <= '{default: '0};
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.ready && r_state != ST_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        if (i_req.data.opcode == stlcg_pkg::OP_RESEED || !r_seeded) begin
                            // The seed sum is already loaded; reduce it.
                            r_mask  <= stlcg_pkg::MASK_A;
                            r_phase <= PH_SEED0;
                            r_state <= ST_QUO;
                        end else begin
                            r_mask  <= stlcg_pkg::MASK_ALL;
                            r_phase <= PH_DRAW;
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    r_state <= ST_QUO;
                end
                ST_QUO: begin
                    r_state <= ST_REM;
                end
                ST_REM: begin
                    r_state <= ST_FIX;
                end
                ST_FIX: begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_mask[i]) begin
                            r_gen[i] <= fix_val[i];
                        end
                    end
                    case (r_phase)
                        PH_SEED0: begin
                            r_mask  <= stlcg_pkg::MASK_A;
                            r_phase <= PH_SEED1;
                            r_state <= ST_MUL;
                        end
                        PH_SEED1: begin
                            r_gen[stlcg_pkg::GEN_B] <= first_mod_b;
                            r_mask  <= stlcg_pkg::MASK_A;
                            r_phase <= PH_SEED2;
                            r_state <= ST_MUL;
                        end
                        PH_SEED2: begin
                            r_gen[stlcg_pkg::GEN_C] <= first_mod_c;
                            r_fill_idx <= '0;
                            r_mask     <= stlcg_pkg::MASK_AB;
                            r_phase    <= PH_FILL;
                            r_state    <= ST_MUL;
                        end
                        default: begin
                            r_state <= ST_PACK;
                        end
                    endcase
                end
                ST_PACK: begin
                    r_state <= (r_phase == PH_FILL) ? ST_FILL : ST_SLOT;
                end
                ST_FILL: begin
                    if (r_fill_idx == FILL_LAST) begin
                        // Table full: finish with the draw itself.
                        r_seeded <= 1'b1;
                        r_mask   <= stlcg_pkg::MASK_ALL;
                        r_phase  <= PH_DRAW;
                    end else begin
                        r_fill_idx <= r_fill_idx + SLOT_W'(1);
                    end
                    r_state <= ST_MUL;
                end
                ST_SLOT: begin
                    r_state <= ST_RW;
                end
                ST_RW: begin
                    r_state <= ST_CV0;
                end
                ST_CV0: begin
                    r_state <= ST_CV1;
                end
                ST_CV1: begin
                    r_state <= ST_CV2;
                end
                ST_CV2: begin
                    r_state <= ST_CV3;
                end
                ST_CV3: begin
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid        <= 1'b1;
                        r_out.deviate_q32  <= r_quo;
                        r_out.combined_raw <= r_rdata;
                        r_state            <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### bench/testbench.sv
// Self-checking testbench for the shuffled three-generator uniform random source.
module testbench;

    // Clock, reset and the two handshake channels of the block.
    logic i_clk;
    logic i_rst_n;

    stlcg_req_if req_ch ();
    stlcg_rsp_if rsp_ch ();

    shuffled_triple_lcg_uniform_rng dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Generator constants of the scheme, kept here at 64 bits so that the
    // predictor never overflows in its products.
    localparam int              SLOT_COUNT = 97;
    localparam longint unsigned FIRST_MOD  = 259200;
    localparam longint unsigned FIRST_MUL  = 7141;
    localparam longint unsigned FIRST_INC  = 54773;
    localparam longint unsigned SECOND_MOD = 134456;
    localparam longint unsigned SECOND_MUL = 8121;
    localparam longint unsigned SECOND_INC = 28411;
    localparam longint unsigned PICKER_MOD = 243000;
    localparam longint unsigned PICKER_MUL = 4561;
    localparam longint unsigned PICKER_INC = 51349;
    localparam longint unsigned VALUE_SPAN = FIRST_MOD * SECOND_MOD;

    // The run is ended by a watchdog if it ever hangs. Its limit leaves a wide
    // margin even if every request reseeded.
    localparam int WATCHDOG_CYCLES = 5_000_000;
    localparam int SETTLE_CYCLES   = 100;

    // Predictor state: the three generators, the shuffle table and whether
    // a seeding has happened since reset.
    longint unsigned gen_first;
    longint unsigned gen_second;
    longint unsigned gen_picker;
    longint unsigned shuffle_slots [SLOT_COUNT];
    bit              is_seeded;

    // Deviates that the block still owes, oldest first.
    stlcg_pkg::t_rsp pending_deviates [$];
    stlcg_pkg::t_rsp oldest_deviate;

    int  error_count;
    int  response_count;
    // When set, both sides run without any idle cycles.
    bit  no_gaps;

    // Clock with a period of 10 time units.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint unsigned lcg_next(longint unsigned v, longint unsigned mul,
                                                 longint unsigned inc, longint unsigned modulus);
        return (mul * v + inc) % modulus;
    endfunction

    // floor(raw * 2^32 / span), done as two 16-bit long-division steps so
    // that nothing exceeds 64 bits.
    function automatic logic [31:0] raw_to_fraction(longint unsigned raw);
        longint unsigned numer;
        longint unsigned upper;
        longint unsigned remainder;
        longint unsigned lower;
        numer     = raw << 16;
        upper     = numer / VALUE_SPAN;
        remainder = numer % VALUE_SPAN;
        lower     = (remainder << 16) / VALUE_SPAN;
        return 32'((upper << 16) + lower);
    endfunction

    // Seeding: generator one starts from the seed, the other two are taken
    // from its next outputs, and the table is filled with one combined value
    // per step of the first two generators.
    function automatic void seed_generators(logic [30:0] magnitude);
        gen_first  = (FIRST_INC + longint'(magnitude)) % FIRST_MOD;
        gen_first  = lcg_next(gen_first, FIRST_MUL, FIRST_INC, FIRST_MOD);
        gen_second = gen_first % SECOND_MOD;
        gen_first  = lcg_next(gen_first, FIRST_MUL, FIRST_INC, FIRST_MOD);
        gen_picker = gen_first % PICKER_MOD;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            gen_first  = lcg_next(gen_first, FIRST_MUL, FIRST_INC, FIRST_MOD);
            gen_second = lcg_next(gen_second, SECOND_MUL, SECOND_INC, SECOND_MOD);
            shuffle_slots[k] = gen_first * SECOND_MOD + gen_second;
        end
        is_seeded = 1'b1;
    endfunction

    // One request in, one deviate out. A reseed, or any draw before the
    // first seeding, seeds first; then all three generators step, the third
    // picks a slot, and the old slot value is returned while a fresh one
    // takes its place.
    function automatic stlcg_pkg::t_rsp predict_deviate(stlcg_pkg::t_req request);
        stlcg_pkg::t_rsp deviate;
        longint unsigned slot;
        longint unsigned previous;
        if (request.opcode == stlcg_pkg::OP_RESEED || !is_seeded) begin
            seed_generators(request.seed_magnitude);
        end
        gen_first  = lcg_next(gen_first, FIRST_MUL, FIRST_INC, FIRST_MOD);
        gen_second = lcg_next(gen_second, SECOND_MUL, SECOND_INC, SECOND_MOD);
        gen_picker = lcg_next(gen_picker, PICKER_MUL, PICKER_INC, PICKER_MOD);
        slot = (SLOT_COUNT * gen_picker) / PICKER_MOD;
        if (slot >= SLOT_COUNT) begin
            slot = SLOT_COUNT - 1;
        end
        previous = shuffle_slots[slot];
        shuffle_slots[slot] = gen_first * SECOND_MOD + gen_second;
        deviate.combined_raw = previous[35:0];
        deviate.deviate_q32  = raw_to_fraction(previous);
        return deviate;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Sends one request. It is entered and left at a falling edge. Idle
    // cycles come first, then valid stays high until the request is taken,
    // and only then is the expected deviate worked out.
    task automatic send_request(logic opcode, logic [30:0] magnitude);
        stlcg_pkg::t_req request;
        request.opcode         = opcode;
        request.seed_magnitude = magnitude;
        while (!no_gaps && $urandom_range(99) < 32) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= request;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_deviates.push_back(predict_deviate(request));
        @(negedge i_clk);
    endtask

    // Drops valid and waits until every owed deviate has come back. It always
    // waits for a falling edge before it returns, so valid never gets two updates
    // in one step.
    task automatic wait_until_drained();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending_deviates.size() != 0);
    endtask

    // A seed field that is often at an edge of its range.
    function automatic logic [30:0] pick_seed();
        case ($urandom_range(7))
            0:       return 31'd0;
            1:       return 31'h7FFF_FFFF;
            2:       return 31'($urandom_range(300000));
            default: return 31'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------

    // The sink is ready with a chance of 68 in a hundred, or always while the
    // no-gap stretch runs.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready <= no_gaps || ($urandom_range(99) >= 32);
        end
    end

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch at response %0d: %s got %h, want %h",
                 response_count, what, got, want);
        error_count++;
    endtask

    // Every accepted response is matched against the oldest owed deviate.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_deviates.size() == 0) begin
                report_mismatch("unrequested response", rsp_ch.data.combined_raw, 0);
            end else begin
                oldest_deviate = pending_deviates.pop_front();
                if (rsp_ch.data.deviate_q32 !== oldest_deviate.deviate_q32) begin
                    report_mismatch("deviate_q32", rsp_ch.data.deviate_q32,
                                    oldest_deviate.deviate_q32);
                end
                if (rsp_ch.data.combined_raw !== oldest_deviate.combined_raw) begin
                    report_mismatch("combined_raw", rsp_ch.data.combined_raw,
                                    oldest_deviate.combined_raw);
                end
            end
            response_count++;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The very first request is a plain draw: it must seed from its seed
    // field just as a reseed would. Later draws ignore the seed field.
    task automatic test_draw_while_unseeded();
        send_request(1'b0, 31'h7FFF_FFFF);
        send_request(1'b0, 31'd12345);
        send_request(1'b0, 31'h5555_5555);
    endtask

    // Seeds at the edges: zero (generator one starts from its increment),
    // the largest magnitude, a seed that wraps generator one to zero, one
    // just below the modulus, and alternating bit patterns.
    task automatic test_seed_extremes();
        logic [30:0] seeds [7];
        seeds = '{31'd0, 31'h7FFF_FFFF, 31'd204427, 31'd259199,
                  31'h5555_5555, 31'h2AAA_AAAA, 31'd1};
        foreach (seeds[k]) begin
            send_request(stlcg_pkg::OP_RESEED, seeds[k]);
            if (k % 2 == 0) begin
                send_request(1'b0, ~seeds[k]);
            end
        end
    endtask

    // The sender holds back until the block has answered everything, so a
    // reseed and the draws after it each start on an idle block.
    task automatic test_reseed_on_idle_block();
        wait_until_drained();
        send_request(stlcg_pkg::OP_RESEED, 31'd4242);
        wait_until_drained();
        send_request(1'b0, 31'd0);
        wait_until_drained();
        send_request(1'b0, 31'h7FFF_FFFF);
    endtask

    // A stretch with no idling on either side, so that each request is offered
    // as soon as the block is back in idle.
    task automatic test_back_to_back(int count);
        no_gaps = 1'b1;
        repeat (count) begin
            send_request($urandom_range(15) == 0, pick_seed());
        end
        no_gaps = 1'b0;
    endtask

    // Mostly draws with random seed fields, with a reseed now and then so
    // that many different tables are walked.
    task automatic test_random_stream(int count);
        repeat (count) begin
            send_request($urandom_range(15) == 0, pick_seed());
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.data    = '0;
        no_gaps        = 1'b0;
        error_count    = 0;
        response_count = 0;
        gen_first      = 0;
        gen_second     = 0;
        gen_picker     = 0;
        is_seeded      = 1'b0;
        foreach (shuffle_slots[k]) begin
            shuffle_slots[k] = 0;
        end

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_draw_while_unseeded();
        test_seed_extremes();
        test_reseed_on_idle_block();
        test_back_to_back(200);
        test_random_stream(1430);

        // Let the last responses come out, then give a stray one time to show.
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        repeat (WATCHDOG_CYCLES) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

endmodule
